// ===== sv/lpht_pkg.sv =====
// Shared types and constants for the linear probe hash table.
package lpht_pkg;
  localparam logic [63:0] HashSeed = 64'h13371337deadbeef;
  localparam int unsigned KeyW = 64;

  typedef enum logic [1:0] {
    FUNC_PUT = 2'd0,
    FUNC_GET = 2'd1,
    FUNC_DEL = 2'd2,
    FUNC_NOP = 2'd3
  } func_e;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE = 2'd1;
  localparam logic [1:0] MARK_TOMB = 2'd2;
endpackage

// ===== sv/lpht_front.sv =====
// Front end: key normalization, byte-serial hash and modulo reduction.
module lpht_front #(
  parameter int unsigned KEY_BYTES = 8,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned SW = 9
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_vld_i,
  input  logic [1:0]             in_func_i,
  input  logic [63:0]            in_key_i,
  input  logic [VALUE_WIDTH-1:0] in_value_i,
  input  logic [SW-1:0]          size_i,
  output logic                   busy_o,
  output logic                   req_vld_o,
  input  logic                   req_rdy_i,
  output logic [1:0]             req_func_o,
  output logic [63:0]            req_key_o,
  output logic [VALUE_WIDTH-1:0] req_value_o,
  output logic [SW-1:0]          req_home_o
);
  import lpht_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StHash = 2'd1;
  localparam logic [1:0] StMod = 2'd2;
  localparam logic [1:0] StOut = 2'd3;
  localparam int unsigned CW = $clog2(KEY_BYTES + 1);

  logic [1:0] st_q, st_d;
  logic [1:0] func_q;
  logic [63:0] key_q, nkey;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [63:0] h_q, h_d;
  logic [CW-1:0] cnt_q;
  logic [6:0] mstep_q;
  logic [SW-1:0] rem_q, rem_d;
  logic [SW:0] rem_sh;
  logic [7:0] b;
  logic [63:0] s;
  logic stop;

  // Normalize: clear bytes from the first zero byte on, and bytes at or beyond KEY_BYTES.
  always_comb begin
    stop = 1'b0;
    nkey = '0;
    for (int i = 0; i < 8; i++) begin
      if (in_key_i[8*i +: 8] == 8'd0 || i >= KEY_BYTES) stop = 1'b1;
      if (!stop) nkey[8*i +: 8] = in_key_i[8*i +: 8];
    end
  end

  assign b = key_q[8*cnt_q +: 8];
  assign s = {{56{b[7]}}, b};
  assign h_d = ((h_q ^ s) << 8) + s;
  // Restoring remainder, one hash bit per cycle, MSB first.
  assign rem_sh = {rem_q, h_q[63 - mstep_q[5:0]]};
  assign rem_d = (rem_sh >= {1'b0, size_i}) ? SW'(rem_sh - {1'b0, size_i})
                                            : rem_sh[SW-1:0];

  assign busy_o = (st_q != StIdle);
  assign req_vld_o = (st_q == StOut);
  assign req_func_o = func_q;
  assign req_key_o = key_q;
  assign req_value_o = val_q;
  assign req_home_o = rem_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (in_vld_i) st_d = StHash;
      StHash: if (cnt_q == CW'(KEY_BYTES) || b == 8'd0) st_d = StMod;
      StMod: if (mstep_q == 7'd63) st_d = StOut;
      StOut: if (req_rdy_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        func_q <= in_func_i;
        key_q <= nkey;
        val_q <= in_value_i;
        h_q <= HashSeed;
        cnt_q <= '0;
        mstep_q <= '0;
        rem_q <= '0;
      end
      StHash: begin
        if (!(cnt_q == CW'(KEY_BYTES) || b == 8'd0)) begin
          h_q <= h_d;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      StMod: begin
        rem_q <= rem_d;
        mstep_q <= mstep_q + 1'b1;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_vld_o |-> req_home_o < size_i) else $error("home slot out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_vld_o && !req_rdy_i) |=> req_vld_o) else $error("request dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIdle && in_vld_i) |=> busy_o) else $error("busy missing");
endmodule

// ===== sv/lpht_back.sv =====
// Back end: probe sequencer over the slot memories and result output.
module lpht_back #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned SW = 9
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_vld_i,
  output logic                   req_rdy_o,
  input  logic [1:0]             req_func_i,
  input  logic [63:0]            req_key_i,
  input  logic [VALUE_WIDTH-1:0] req_value_i,
  input  logic [SW-1:0]          req_home_i,
  input  logic [SW-1:0]          size_i,
  output logic                   clearing_o,
  output logic                   res_vld_o,
  output logic [1:0]             status_o,
  output logic [31:0]            read_value_o,
  output logic [7:0]             slot_index_o,
  output logic [8:0]             entry_count_o
);
  import lpht_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [2:0] StClr = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StRd = 3'd2;
  localparam logic [2:0] StChk = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [63:0] key_mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] val_mem [TABLE_DEPTH];
  logic [1:0] mark_mem [TABLE_DEPTH];

  logic [2:0] st_q;
  logic [AW-1:0] idx_q, clr_q, tomb_q, hit_q;
  logic [SW-1:0] n_q;
  logic have_tomb_q, found_q, empty_q;
  logic [1:0] func_q;
  logic [63:0] key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [63:0] rkey_q;
  logic [VALUE_WIDTH-1:0] rval_q;
  logic [1:0] rmark_q;
  logic [8:0] cnt_q;
  logic [AW-1:0] idx_nx;
  logic [SW-1:0] idx_ext;

  logic wr_en;
  logic [AW-1:0] wr_a;
  logic [1:0] wr_mark;
  logic wr_kv;

  assign idx_ext = SW'(idx_q) + 1'b1;
  assign idx_nx = (idx_ext >= size_i) ? '0 : idx_ext[AW-1:0];
  assign req_rdy_o = (st_q == StIdle);
  assign clearing_o = (st_q == StClr);

  always_ff @(posedge clk_i) begin
    rkey_q <= key_mem[idx_q];
    rval_q <= val_mem[hit_q];
    rmark_q <= mark_mem[idx_q];
    if (wr_en) begin
      mark_mem[wr_a] <= wr_mark;
      if (wr_kv) begin
        key_mem[wr_a] <= key_q;
        val_mem[wr_a] <= val_q;
      end
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_a = '0;
    wr_mark = MARK_EMPTY;
    wr_kv = 1'b0;
    if (st_q == StClr) begin
      wr_en = 1'b1;
      wr_a = clr_q;
    end else if (st_q == StDone) begin
      if (func_q == FUNC_PUT && found_q) begin
        wr_en = 1'b1; wr_a = hit_q; wr_mark = MARK_LIVE; wr_kv = 1'b1;
      end else if (func_q == FUNC_PUT && (have_tomb_q || empty_q)) begin
        wr_en = 1'b1; wr_a = have_tomb_q ? tomb_q : idx_q;
        wr_mark = MARK_LIVE; wr_kv = 1'b1;
      end else if (func_q == FUNC_DEL && found_q) begin
        wr_en = 1'b1; wr_a = hit_q; wr_mark = MARK_TOMB;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr;
      clr_q <= '0;
      cnt_q <= '0;
      res_vld_o <= 1'b0;
    end else begin
      res_vld_o <= (st_q == StDone);
      unique case (st_q)
        StClr: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(TABLE_DEPTH - 1)) st_q <= StIdle;
        end
        StIdle: if (req_vld_i) st_q <= (req_func_i == FUNC_NOP) ? StDone : StRd;
        StRd: st_q <= StChk;
        StChk: begin
          if (rmark_q == MARK_EMPTY || (rmark_q == MARK_LIVE && rkey_q == key_q)
              || n_q == size_i - 1'b1) st_q <= StDone;
          else st_q <= StRd;
        end
        StDone: begin
          st_q <= StIdle;
          if (func_q == FUNC_PUT && !found_q && (have_tomb_q || empty_q))
            cnt_q <= cnt_q + 1'b1;
          else if (func_q == FUNC_DEL && found_q && cnt_q != 9'd0)
            cnt_q <= cnt_q - 1'b1;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        func_q <= req_func_i;
        key_q <= req_key_i;
        val_q <= req_value_i;
        idx_q <= req_home_i[AW-1:0];
        hit_q <= '0;
        n_q <= '0;
        have_tomb_q <= 1'b0;
        found_q <= 1'b0;
        empty_q <= 1'b0;
      end
      StChk: begin
        if (rmark_q == MARK_EMPTY) begin
          empty_q <= 1'b1;
        end else if (rmark_q == MARK_LIVE && rkey_q == key_q) begin
          found_q <= 1'b1;
          hit_q <= idx_q;
        end else begin
          if (rmark_q != MARK_LIVE && !have_tomb_q) begin
            have_tomb_q <= 1'b1;
            tomb_q <= idx_q;
          end
          if (n_q != size_i - 1'b1) begin
            idx_q <= idx_nx;
            n_q <= n_q + 1'b1;
          end
        end
      end
      StDone: begin
        if (func_q == FUNC_NOP) begin
          status_o <= STATUS_MISS;
          slot_index_o <= '0;
        end else if (found_q) begin
          status_o <= STATUS_OK;
          slot_index_o <= 8'(hit_q);
        end else if (func_q == FUNC_PUT && (have_tomb_q || empty_q)) begin
          status_o <= STATUS_OK;
          slot_index_o <= 8'(have_tomb_q ? tomb_q : idx_q);
        end else begin
          status_o <= (func_q == FUNC_PUT) ? STATUS_FULL : STATUS_MISS;
          slot_index_o <= '0;
        end
      end
      default: ;
    endcase
  end

  // Value read goes through the registered port of the hit slot, aligned with the result strobe.
  logic get_hit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) get_hit_q <= 1'b0;
    else if (st_q == StDone) get_hit_q <= (func_q == FUNC_GET) && found_q;
  end
  assign read_value_o = get_hit_q ? 32'(rval_q) : 32'd0;
  assign entry_count_o = cnt_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o |-> $past(st_q) == StDone) else $error("stray result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StChk |-> n_q < size_i) else $error("probe overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && status_o != STATUS_OK) |-> slot_index_o == 8'd0)
    else $error("slot on failure");
endmodule

// ===== sv/linear_probe_hash_table_core.sv =====
// Top level of the linear probe hash table.
// A request passes the byte-serial hash, the bit-serial remainder, a read and a check state per probe, then done.
// Throughput: busy is high while the front end hashes; it hands off and frees up when the
// back end takes the request, so the next hash overlaps the previous probe sequence.
// The result is shown for one cycle on done_o; the receiver cannot stall.
// After reset a clearing pass over all TABLE_DEPTH slots empties the marks; busy is high.
module linear_probe_hash_table_core #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_BYTES = 8,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [63:0] key_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] read_value_o,
  output logic [7:0]  slot_index_o,
  output logic [8:0]  entry_count_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);
  import lpht_pkg::*;

  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);

  logic [8:0] size_q;
  logic [SW-1:0] eff;
  logic fbusy, rvld, rrdy, clearing;
  logic [1:0] rfunc;
  logic [63:0] rkey;
  logic [VALUE_WIDTH-1:0] rval;
  logic [SW-1:0] rhome;
  logic [VALUE_WIDTH-1:0] vin;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= 9'd256;
    else if (cfg_valid && cfg_ready) size_q <= cfg_data;
  end

  always_comb begin
    if (size_q == 9'd0) eff = SW'(1);
    else if (32'(size_q) > TABLE_DEPTH) eff = SW'(TABLE_DEPTH);
    else eff = SW'(size_q);
  end

  assign vin = VALUE_WIDTH'(value_i);
  assign busy = fbusy || clearing || rvld;

  lpht_front #(.KEY_BYTES(KEY_BYTES), .VALUE_WIDTH(VALUE_WIDTH), .SW(SW)) u_front (
    .clk_i, .rst_ni, .in_vld_i(start && !busy), .in_func_i(func_i), .in_key_i(key_i),
    .in_value_i(vin), .size_i(eff), .busy_o(fbusy), .req_vld_o(rvld), .req_rdy_i(rrdy),
    .req_func_o(rfunc), .req_key_o(rkey), .req_value_o(rval), .req_home_o(rhome)
  );

  logic bbusy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bbusy_q <= 1'b0;
    else if (rvld && rrdy) bbusy_q <= 1'b1;
    else if (done_o) bbusy_q <= 1'b0;
  end

  lpht_back #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH), .SW(SW)) u_back (
    .clk_i, .rst_ni, .req_vld_i(rvld), .req_rdy_o(rrdy), .req_func_i(rfunc),
    .req_key_i(rkey), .req_value_i(rval), .req_home_i(rhome), .size_i(eff),
    .clearing_o(clearing), .res_vld_o(done_o), .status_o(status_o),
    .read_value_o(read_value_o), .slot_index_o(slot_index_o),
    .entry_count_o(entry_count_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !bbusy_q || $past(bbusy_q)) else $error("result without request");
endmodule

// ===== tb/lpht_checker.sv =====
// Request/result checker for the linear probe hash table core.
`timescale 1ns / 1ps
module lpht_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  func_i,
  input  logic [63:0] key_i,
  input  logic [31:0] value_i,
  input  logic        done_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] read_value_i,
  input  logic [7:0]  slot_index_i,
  input  logic [8:0]  entry_count_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [8:0]  cfg_data_i,
  output int          pending_o,
  output int          fail_count_o
);
  import lpht_pkg::*;

  localparam int Depth = 256;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [7:0]  slot_index;
    logic [8:0]  entry_count;
  } lookup_result_t;

  logic [63:0] slot_key_q [Depth];
  logic [31:0] slot_val_q [Depth];
  logic [1:0]  slot_mark_q[Depth];
  logic [8:0]  live_q;
  logic [8:0]  size_q;
  lookup_result_t expected_q[$];

  assign pending_o = expected_q.size();

  task automatic run_lookup(input logic [1:0] fn, input logic [63:0] raw_key,
                            input logic [31:0] val, output lookup_result_t res);
    logic [63:0] k;
    logic [63:0] h;
    logic [63:0] s;
    logic [7:0]  b;
    int          len;
    int          sz;
    int          idx;
    int          tomb;
    int          slot;
    bit          have_tomb;
    bit          hit_empty;
    bit          found;
    logic [31:0] rv;
    k = '0;
    len = 0;
    for (int i = 0; i < 8; i++) begin
      b = raw_key[8*i +: 8];
      if (b == 8'd0) break;
      k[8*i +: 8] = b;
      len++;
    end
    h = HashSeed;
    for (int i = 0; i < len; i++) begin
      b = k[8*i +: 8];
      s = {{56{b[7]}}, b};
      h = ((h ^ s) << 8) + s;
    end
    sz = (size_q == 0) ? 1 : (size_q > Depth) ? Depth : size_q;
    idx = int'(h % 64'(sz));
    have_tomb = 0;
    hit_empty = 0;
    found = 0;
    tomb = 0;
    slot = 0;
    rv = '0;
    if (fn != FUNC_NOP) begin
      for (int i = 0; i < sz; i++) begin
        if (slot_mark_q[idx] == MARK_EMPTY) begin
          hit_empty = 1;
          break;
        end
        if (slot_mark_q[idx] == MARK_LIVE && slot_key_q[idx] == k) begin
          found = 1;
          slot = idx;
          break;
        end
        if (slot_mark_q[idx] != MARK_LIVE && !have_tomb) begin
          have_tomb = 1;
          tomb = idx;
        end
        idx = (idx + 1 >= sz) ? 0 : idx + 1;
      end
    end
    res.status = found ? STATUS_OK : STATUS_MISS;
    case (fn)
      FUNC_PUT: begin
        if (found) begin
          slot_val_q[slot] = val;
        end else if (have_tomb || hit_empty) begin
          slot = have_tomb ? tomb : idx;
          slot_key_q[slot] = k;
          slot_val_q[slot] = val;
          slot_mark_q[slot] = MARK_LIVE;
          live_q++;
          res.status = STATUS_OK;
        end else begin
          res.status = STATUS_FULL;
        end
      end
      FUNC_GET: if (found) rv = slot_val_q[slot];
      FUNC_DEL: begin
        if (found) begin
          slot_mark_q[slot] = MARK_TOMB;
          if (live_q > 0) live_q--;
        end
      end
      default: ;
    endcase
    res.read_value = rv;
    res.slot_index = (res.status == STATUS_OK) ? 8'(slot) : 8'd0;
    res.entry_count = live_q;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] got);
    if (exp !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t r;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) slot_mark_q[i] = MARK_EMPTY;
      live_q = '0;
      size_q = 9'd256;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      // Result first: a request accepted this edge cannot already be answered.
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0h", $time, status_i);
          fail_count_o++;
        end else begin
          r = expected_q.pop_front();
          check_field("status", 32'(r.status), 32'(status_i));
          check_field("read_value", r.read_value, read_value_i);
          check_field("slot_index", 32'(r.slot_index), 32'(slot_index_i));
          check_field("entry_count", 32'(r.entry_count), 32'(entry_count_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) size_q = cfg_data_i;
      if (start_i && !busy_i) begin
        run_lookup(func_i, key_i, value_i, r);
        expected_q.push_back(r);
      end
    end
  end
endmodule

// ===== tb/tb_linear_probe_hash_table_core.sv =====
// Testbench top: stimulus, table size phases and verdict for the hash table core.
`timescale 1ns / 1ps
module tb_linear_probe_hash_table_core;
  import lpht_pkg::*;

  localparam int CycleLimit = 4000000;
  localparam int PoolSize = 32;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func_q = FUNC_NOP;
  logic [63:0] key_q = '0;
  logic [31:0] value_q = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] read_value_o;
  logic [7:0]  slot_index_o;
  logic [8:0]  entry_count_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;
  int          pending;
  int          fail_count;
  int          cycles = 0;
  bit          idle_on = 1'b1;

  logic [63:0] key_pool[PoolSize];
  int          key_len [PoolSize];

  always #6 clk_i = ~clk_i;

  linear_probe_hash_table_core i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .func_i(func_q), .key_i(key_q), .value_i(value_q),
    .done_o, .status_o, .read_value_o, .slot_index_o, .entry_count_o,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  lpht_checker i_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .func_i(func_q), .key_i(key_q), .value_i(value_q),
    .done_i(done_o), .status_i(status_o), .read_value_i(read_value_o),
    .slot_index_i(slot_index_o), .entry_count_i(entry_count_o),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("linear_probe_hash_table_core test failed");
      $finish;
    end
  end

  task automatic send_request(input func_e fn, input logic [63:0] k, input logic [31:0] v);
    if (idle_on && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    func_q <= fn;
    key_q <= k;
    value_q <= v;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
  endtask

  task automatic write_size(input logic [8:0] sz);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= sz;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic refill_pool();
    for (int p = 0; p < PoolSize; p++) begin
      key_len[p] = $urandom_range(0, 8);
      key_pool[p] = '0;
      for (int i = 0; i < key_len[p]; i++) key_pool[p][8*i +: 8] = 8'($urandom_range(1, 255));
    end
  endtask

  // Pool key with fresh garbage after the terminating zero byte.
  function automatic logic [63:0] pick_key();
    int p;
    logic [63:0] k;
    p = $urandom_range(0, PoolSize - 1);
    k = key_pool[p];
    for (int i = key_len[p] + 1; i < 8; i++) k[8*i +: 8] = 8'($urandom);
    return k;
  endfunction

  initial begin
    logic [8:0] phase_size[11];
    int r;
    func_e fn;
    logic [63:0] k;
    phase_size = '{9'd256, 9'd1, 9'd2, 9'd5, 9'd16, 9'd64, 9'd0, 9'd300,
                   9'd511, 9'd3, 9'd256};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty key, full-width key, sign bit bytes, garbage after terminator
    send_request(FUNC_GET, 64'h0, 32'h0);
    send_request(FUNC_PUT, 64'h0, 32'hffff_ffff);
    send_request(FUNC_GET, 64'hff00_0000_0000_0000, 32'h0);
    send_request(FUNC_PUT, 64'hffff_ffff_ffff_ffff, 32'h1234_5678);
    send_request(FUNC_PUT, 64'h0000_0000_0000_0080, 32'h0000_0001);
    send_request(FUNC_PUT, 64'hdead_beef_0000_0042, 32'hcafe_f00d);
    send_request(FUNC_GET, 64'h1234_5678_9a00_0042, 32'h0);
    send_request(FUNC_GET, 64'hffff_ffff_ffff_ffff, 32'h0);
    send_request(FUNC_PUT, 64'hffff_ffff_ffff_ffff, 32'h0);
    send_request(FUNC_GET, 64'hffff_ffff_ffff_ffff, 32'h0);
    send_request(FUNC_DEL, 64'h0000_0000_0000_0042, 32'h0);
    send_request(FUNC_DEL, 64'h0000_0000_0000_0042, 32'h0);
    send_request(FUNC_GET, 64'h0000_0000_0000_0042, 32'h0);
    send_request(FUNC_NOP, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
    send_request(FUNC_GET, 64'h0000_0000_0000_0080, 32'h0);
    // size 1: collision, full table, tombstone reuse
    write_size(9'd1);
    send_request(FUNC_PUT, 64'h41, 32'h11);
    send_request(FUNC_PUT, 64'h42, 32'h22);
    send_request(FUNC_GET, 64'h42, 32'h0);
    send_request(FUNC_DEL, 64'h41, 32'h0);
    send_request(FUNC_PUT, 64'h42, 32'h22);
    send_request(FUNC_GET, 64'h42, 32'h0);
    send_request(FUNC_GET, 64'h41, 32'h0);

    for (int ph = 0; ph < 11; ph++) begin
      write_size(phase_size[ph]);
      refill_pool();
      idle_on = (ph != 4);
      for (int n = 0; n < 150; n++) begin
        r = $urandom_range(0, 99);
        fn = (r < 45) ? FUNC_PUT : (r < 80) ? FUNC_GET : (r < 97) ? FUNC_DEL : FUNC_NOP;
        k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : pick_key();
        send_request(fn, k, $urandom);
        if (ph == 0 && n == 75) drain();
      end
    end

    drain();
    repeat (700) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("linear_probe_hash_table_core test passed");
    end else begin
      $display("linear_probe_hash_table_core test failed");
    end
    $finish;
  end
endmodule
